FILE: rtl/mm_pkg.sv
// Shared constants, codes, state type and controller/datapath structs
// for the matrix multiply core. No dependencies.
`default_nettype none

package mm_pkg;

    localparam int MAX_DIM   = 8;
    localparam int ELEM_W    = 16;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W     = 36;

    localparam int IDX_W  = $clog2(MAX_DIM);
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SIZE_W = 2 * DIM_W;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int ADD_W  = ((PROD_W > SUM_W) ? PROD_W : SUM_W) + 1;

    localparam logic signed [SUM_W-1:0] SUM_HI = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_LO = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(8);

    localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = CFG_IDX_W'(2);

    localparam logic OP_LOAD_A = 1'b0;
    localparam logic OP_LOAD_B = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SYNC,
        S_MAC,
        S_DRAIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] inner;
        logic [DIM_W-1:0] cols;
    } t_dims;

    typedef struct packed {
        logic load;
        logic sync_start;
        logic sync_step;
        logic mac_begin;
        logic mac_issue;
        logic out_load;
        logic clear_counts;
    } t_cmd;

    typedef struct packed {
        logic complete;
        logic sync_done;
        logic t_last;
        logic ij_last;
        logic pipe_busy;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

FILE: rtl/mm_in_if.sv
// Input channel of the matrix multiply core: valid/ready plus element word.
// Depends on mm_pkg.
`default_nettype none

interface mm_in_if;
    import mm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic signed [ELEM_W-1:0] element_value;

    modport source (output valid, output opcode, output element_value, input ready);
    modport sink   (input valid, input opcode, input element_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/mm_out_if.sv
// Output channel of the matrix multiply core: valid/ready plus result word.
// Depends on mm_pkg.
`default_nettype none

interface mm_out_if;
    import mm_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [SUM_W-1:0] product_value;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic                    last_element;

    modport source (output valid, output product_value, output out_row, output out_col,
                    output last_element, input ready);
    modport sink   (input valid, input product_value, input out_row, input out_col,
                    input last_element, output ready);
endinterface

`default_nettype wire

FILE: rtl/mm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

FILE: rtl/mm_ctrl.sv
// Controller FSM of the matrix multiply core: sequences loads, pointer
// resync, MAC passes and result handoff. Depends on mm_pkg.
`default_nettype none

module mm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_in_valid,
    input  mm_pkg::t_status i_st,
    output logic            o_in_ready,
    output mm_pkg::t_cmd    o_cmd
);
    import mm_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_sync_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sync_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sync_pend <= i_cfg_we | (r_sync_pend & ~o_cmd.sync_start);
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = ~r_sync_pend;
                if (r_sync_pend) begin
                    o_cmd.sync_start = 1'b1;
                    n_state          = S_SYNC;
                end else if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_SYNC: begin
                if (i_st.sync_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.sync_step = 1'b1;
                end
            end
            S_CHECK: begin
                if (i_st.complete) begin
                    o_cmd.mac_begin = 1'b1;
                    n_state         = S_MAC;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MAC: begin
                o_cmd.mac_issue = 1'b1;
                if (i_st.t_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_st.pipe_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_st.ij_last) begin
                        o_cmd.clear_counts = 1'b1;
                        n_state            = S_IDLE;
                    end else begin
                        n_state = S_MAC;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

`default_nettype wire

FILE: rtl/mm_dp.sv
// Datapath of the matrix multiply core: element stores, load pointers,
// shared MAC pipeline and output register. Depends on mm_pkg, mm_ram, mm_out_if.
`default_nettype none

module mm_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  mm_pkg::t_dims                    i_dims,
    input  mm_pkg::t_cmd                     i_cmd,
    input  logic                             i_opcode,
    input  logic signed [mm_pkg::ELEM_W-1:0] i_element_value,
    output mm_pkg::t_status                  o_st,
    mm_out_if.source                         o_out
);
    import mm_pkg::*;

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [IDX_W-1:0] row,
                                                   input logic [IDX_W-1:0] col);
        return ADDR_W'(int'(row) * MAX_DIM + int'(col));
    endfunction

    function automatic logic [IDX_W-1:0] row_inc(input logic [IDX_W-1:0] row);
        return (row == IDX_W'(MAX_DIM - 1)) ? '0 : row + 1'b1;
    endfunction

    // load pointers
    logic [CNT_W-1:0] r_cnt_a, r_cnt_b, r_walk_a, r_walk_b;
    logic [IDX_W-1:0] r_row_a, r_col_a, r_row_b, r_col_b;
    logic [SIZE_W-1:0] w_size_a, w_size_b;
    logic w_full_a, w_full_b, w_wrap_a, w_wrap_b, w_load_a, w_load_b;
    logic w_walk_a, w_walk_b;
    logic [IDX_W-1:0] n_row_a, n_col_a, n_row_b, n_col_b;

    // MAC
    logic [IDX_W-1:0] r_i, r_j, r_t;
    logic w_t_last, w_j_last, w_i_last;
    logic r_v1, r_v2;
    logic [ELEM_W-1:0] w_rd_a_raw, w_rd_b_raw;
    logic signed [ELEM_W-1:0] w_rd_a, w_rd_b;
    logic signed [PROD_W-1:0] w_mul, r_prod;
    logic signed [ADD_W-1:0] w_sum;
    logic signed [SUM_W-1:0] r_acc, n_acc;

    // output register
    logic                    r_out_valid;
    logic signed [SUM_W-1:0] r_out_value;
    logic [IDX_W-1:0]        r_out_row, r_out_col;
    logic                    r_out_last;

    assign w_size_a = {{DIM_W{1'b0}}, i_dims.rows}  * {{DIM_W{1'b0}}, i_dims.inner};
    assign w_size_b = {{DIM_W{1'b0}}, i_dims.inner} * {{DIM_W{1'b0}}, i_dims.cols};
    assign w_full_a = int'(r_cnt_a) >= int'(w_size_a);
    assign w_full_b = int'(r_cnt_b) >= int'(w_size_b);

    assign w_wrap_a = (DIM_W'(r_col_a) + DIM_W'(1)) == i_dims.inner;
    assign w_wrap_b = (DIM_W'(r_col_b) + DIM_W'(1)) == i_dims.cols;
    assign n_col_a  = w_wrap_a ? '0 : r_col_a + 1'b1;
    assign n_col_b  = w_wrap_b ? '0 : r_col_b + 1'b1;
    assign n_row_a  = w_wrap_a ? row_inc(r_row_a) : r_row_a;
    assign n_row_b  = w_wrap_b ? row_inc(r_row_b) : r_row_b;

    assign w_load_a = i_cmd.load && (i_opcode == OP_LOAD_A) && !w_full_a;
    assign w_load_b = i_cmd.load && (i_opcode == OP_LOAD_B) && !w_full_b;
    assign w_walk_a = r_walk_a != r_cnt_a;
    assign w_walk_b = r_walk_b != r_cnt_b;

    // pointers are re-walked from zero after a register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_counts) begin
            r_cnt_a  <= '0;
            r_walk_a <= '0;
            r_row_a  <= '0;
            r_col_a  <= '0;
        end else if (w_load_a) begin
            r_cnt_a <= r_cnt_a + 1'b1;
            r_row_a <= n_row_a;
            r_col_a <= n_col_a;
        end else if (i_cmd.sync_start) begin
            r_walk_a <= '0;
            r_row_a  <= '0;
            r_col_a  <= '0;
        end else if (i_cmd.sync_step && w_walk_a) begin
            r_walk_a <= r_walk_a + 1'b1;
            r_row_a  <= n_row_a;
            r_col_a  <= n_col_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_counts) begin
            r_cnt_b  <= '0;
            r_walk_b <= '0;
            r_row_b  <= '0;
            r_col_b  <= '0;
        end else if (w_load_b) begin
            r_cnt_b <= r_cnt_b + 1'b1;
            r_row_b <= n_row_b;
            r_col_b <= n_col_b;
        end else if (i_cmd.sync_start) begin
            r_walk_b <= '0;
            r_row_b  <= '0;
            r_col_b  <= '0;
        end else if (i_cmd.sync_step && w_walk_b) begin
            r_walk_b <= r_walk_b + 1'b1;
            r_row_b  <= n_row_b;
            r_col_b  <= n_col_b;
        end
    end

    mm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (w_load_a),
        .i_waddr (mem_addr(r_row_a, r_col_a)),
        .i_wdata (i_element_value),
        .i_re    (i_cmd.mac_issue),
        .i_raddr (mem_addr(r_i, r_t)),
        .o_rdata (w_rd_a_raw)
    );

    mm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (w_load_b),
        .i_waddr (mem_addr(r_row_b, r_col_b)),
        .i_wdata (i_element_value),
        .i_re    (i_cmd.mac_issue),
        .i_raddr (mem_addr(r_t, r_j)),
        .o_rdata (w_rd_b_raw)
    );

    assign w_rd_a   = $signed(w_rd_a_raw);
    assign w_rd_b   = $signed(w_rd_b_raw);
    assign w_t_last = (DIM_W'(r_t) + DIM_W'(1)) == i_dims.inner;
    assign w_j_last = (DIM_W'(r_j) + DIM_W'(1)) == i_dims.cols;
    assign w_i_last = (DIM_W'(r_i) + DIM_W'(1)) == i_dims.rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.mac_begin) begin
            r_i <= '0;
            r_j <= '0;
            r_t <= '0;
        end else begin
            if (i_cmd.mac_issue) begin
                r_t <= w_t_last ? '0 : r_t + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_j <= w_j_last ? '0 : r_j + 1'b1;
                r_i <= w_j_last ? r_i + 1'b1 : r_i;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac_issue;
            r_v2 <= r_v1;
        end
    end

    assign w_mul = w_rd_a * w_rd_b;
    assign w_sum = ADD_W'(r_acc) + ADD_W'(r_prod);

    always_comb begin
        if (w_sum > ADD_W'(SUM_HI)) begin
            n_acc = SUM_HI;
        end else if (w_sum < ADD_W'(SUM_LO)) begin
            n_acc = SUM_LO;
        end else begin
            n_acc = SUM_W'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= w_mul;
        end
        if (i_cmd.mac_begin || i_cmd.out_load) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value <= r_acc;
            r_out_row   <= r_i;
            r_out_col   <= r_j;
            r_out_last  <= w_i_last && w_j_last;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.product_value = r_out_value;
    assign o_out.out_row       = r_out_row;
    assign o_out.out_col       = r_out_col;
    assign o_out.last_element  = r_out_last;

    assign o_st.complete  = w_full_a && w_full_b;
    assign o_st.sync_done = !w_walk_a && !w_walk_b;
    assign o_st.t_last    = w_t_last;
    assign o_st.ij_last   = w_i_last && w_j_last;
    assign o_st.pipe_busy = r_v1 || r_v2;
    assign o_st.out_free  = !r_out_valid || o_out.ready;
endmodule

`default_nettype wire

FILE: rtl/matrix_multiply_core.sv
// Channel  Dir  Word                                              Handshake
// i_in     in   opcode, element_value                             valid/ready
// o_out    out  product_value, out_row, out_col, last_element     valid/ready
// cfg      in   i_cfg_idx, i_cfg_data                             i_cfg_we, never stalls
//
// A load word is handled as a store write, then the completion test.
// Each result is computed on the single shared MAC fed by the
// registered-read element RAMs; a stalled o_out holds the next result back.
// After a register write, i_in.ready stays low while the load pointers are
// re-walked from the element counts.
// Reset is synchronous and clears counts and control; the stores keep contents.
`default_nettype none

module matrix_multiply_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [mm_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mm_pkg::CFG_W-1:0]       i_cfg_data,
    mm_in_if.sink                          i_in,
    mm_out_if.source                       o_out
);
    import mm_pkg::*;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        if (v == '0) begin
            return DIM_W'(1);
        end else if (int'(v) > MAX_DIM) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(v);
    endfunction

    logic [CFG_W-1:0] r_rows_a, r_inner_dim, r_cols_b;
    t_dims            w_dims;
    t_cmd             w_cmd;
    t_status          w_st;
    logic             w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= CFG_RESET;
            r_inner_dim <= CFG_RESET;
            r_cols_b    <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROWS_A:    r_rows_a    <= i_cfg_data;
                REG_INNER_DIM: r_inner_dim <= i_cfg_data;
                REG_COLS_B:    r_cols_b    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign w_dims.rows  = eff_dim(r_rows_a);
    assign w_dims.inner = eff_dim(r_inner_dim);
    assign w_dims.cols  = eff_dim(r_cols_b);

    mm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_in_valid (i_in.valid),
        .i_st       (w_st),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    mm_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dims          (w_dims),
        .i_cmd           (w_cmd),
        .i_opcode        (i_in.opcode),
        .i_element_value (i_in.element_value),
        .o_st            (w_st),
        .o_out           (o_out)
    );

    assign i_in.ready = w_in_ready;
endmodule

`default_nettype wire

FILE: rtl/mm_chk.sv
// Port-level checker for matrix_multiply_core, bound to the top level.
// Depends on mm_in_if and mm_out_if.
`default_nettype none

module mm_chk (
    input logic      i_clk,
    input logic      i_rst_n,
    mm_in_if.sink    i_in,
    mm_out_if.source o_out
);
    a_rst_no_valid: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.product_value)
            && $stable(o_out.out_row) && $stable(o_out.out_col)
            && $stable(o_out.last_element))
        else $error("stalled result word changed");

    a_check_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("ready high in completion test cycle");

    a_no_direct_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> !$past(i_in.valid && i_in.ready))
        else $error("result raised right after a load word");
endmodule

bind matrix_multiply_core mm_chk u_mm_chk (.*);

`default_nettype wire

FILE: tb/tb_matrix_multiply_core.sv
// Self-checking testbench for matrix_multiply_core: a directed table, then random
// load sequences, every product word checked against an in-bench predictor.
// Depends on mm_pkg, mm_in_if, mm_out_if and the core RTL.
module tb_matrix_multiply_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mm_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_WORDS  = 120;
    localparam int PLAN_LEN      = 32;
    localparam logic [CFG_W-1:0] CFG_TOP = '1;

    typedef struct packed {
        logic signed [SUM_W-1:0] value;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic                    last;
    } t_product;

    typedef struct packed {
        logic                     is_reg;
        logic [CFG_IDX_W-1:0]     idx;
        logic [CFG_W-1:0]         data;
        logic                     op;
        logic signed [ELEM_W-1:0] val;
        logic                     typed;
        logic signed [SUM_W-1:0]  typed_value;
    } t_step;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    mm_in_if  in_if ();
    mm_out_if out_if ();

    matrix_multiply_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predictor state
    logic [CFG_W-1:0]         dim_reg [3];
    logic signed [ELEM_W-1:0] elem_a [DEPTH];
    logic signed [ELEM_W-1:0] elem_b [DEPTH];
    int unsigned              loaded_a = 0;
    int unsigned              loaded_b = 0;
    t_product                 product_q [$];

    int    fail_count = 0;
    int    quiet      = 0;
    int    burst_left = 0;
    bit    calm       = 1'b0;
    bit    hold_req   = 1'b0;
    t_step plan [PLAN_LEN];

    function automatic int unsigned eff_dim(input logic [CFG_W-1:0] raw);
        if (raw == '0) return 1;
        if (raw > MAX_DIM) return MAX_DIM;
        return int'(raw);
    endfunction

    // Loads one word; on completion queues the whole product, returns its word count.
    function automatic int predict_word(input logic op, input logic signed [ELEM_W-1:0] val,
                                        output bit took);
        int unsigned nr;
        int unsigned nk;
        int unsigned nc;
        longint      acc;
        t_product    p;
        int          n;
        nr = eff_dim(dim_reg[REG_ROWS_A]);
        nk = eff_dim(dim_reg[REG_INNER_DIM]);
        nc = eff_dim(dim_reg[REG_COLS_B]);
        took = 1'b0;
        n = 0;
        if (op == OP_LOAD_A) begin
            if (loaded_a < nr * nk) begin
                elem_a[(loaded_a / nk) * MAX_DIM + loaded_a % nk] = val;
                loaded_a++;
                took = 1'b1;
            end
        end else if (loaded_b < nk * nc) begin
            elem_b[(loaded_b / nc) * MAX_DIM + loaded_b % nc] = val;
            loaded_b++;
            took = 1'b1;
        end
        if (loaded_a < nr * nk || loaded_b < nk * nc) return 0;
        for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
                acc = 0;
                for (int t = 0; t < nk; t++) begin
                    acc += longint'(elem_a[i * MAX_DIM + t]) * longint'(elem_b[t * MAX_DIM + j]);
                    if (acc > SUM_HI) acc = SUM_HI;
                    else if (acc < SUM_LO) acc = SUM_LO;
                end
                p.value = SUM_W'(acc);
                p.row   = IDX_W'(i);
                p.col   = IDX_W'(j);
                p.last  = (i == nr - 1) && (j == nc - 1);
                product_q.push_back(p);
                n++;
            end
        end
        loaded_a = 0;
        loaded_b = 0;
        return n;
    endfunction

    function automatic t_step reg_row(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] data);
        t_step s;
        s = '0;
        s.is_reg = 1'b1;
        s.idx    = idx;
        s.data   = data;
        return s;
    endfunction

    function automatic t_step word_row(input logic op, input logic signed [ELEM_W-1:0] val,
                                       input logic typed = 1'b0,
                                       input logic signed [SUM_W-1:0] typed_value = '0);
        t_step s;
        s = '0;
        s.op          = op;
        s.val         = val;
        s.typed       = typed;
        s.typed_value = typed_value;
        return s;
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim(input bit go_big, input bit go_one);
        if (go_big) return CFG_W'($urandom_range(MAX_DIM, CFG_TOP));
        if (go_one) return CFG_W'($urandom_range(0, 1));
        if ($urandom_range(0, 7) == 0) return CFG_W'($urandom_range(MAX_DIM, CFG_TOP));
        return CFG_W'($urandom_range(0, 3));
    endfunction

    function automatic logic signed [ELEM_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return {1'b1, {(ELEM_W-1){1'b0}}};
            1: return {1'b0, {(ELEM_W-1){1'b1}}};
            2: return '0;
            default: return ELEM_W'($urandom());
        endcase
    endfunction

    // Bursty sender: returns at the edge where the word was taken.
    task automatic offer_word(input logic op, input logic signed [ELEM_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = calm ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_if.valid         <= 1'b1;
        in_if.opcode        <= op;
        in_if.element_value <= val;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        burst_left = 0;
        while (product_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        dim_reg[idx] = data;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_step                    s;
        t_product                 fixed;
        bit                       took;
        int                       produced;
        int                       counted;
        int                       ph;
        logic                     op;
        logic signed [ELEM_W-1:0] val;
        int unsigned              size_a;
        int unsigned              size_b;

        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= REG_ROWS_A;
        i_cfg_data          <= '0;
        in_if.valid         <= 1'b0;
        in_if.opcode        <= OP_LOAD_A;
        in_if.element_value <= '0;
        foreach (dim_reg[n]) dim_reg[n] = CFG_RESET;

        plan = '{
            reg_row(REG_ROWS_A, 4'd0),
            reg_row(REG_INNER_DIM, 4'd0),
            reg_row(REG_COLS_B, 4'd0),
            word_row(OP_LOAD_A, 16'sh8000),
            word_row(OP_LOAD_B, 16'sh8000, 1'b1, 36'sd1073741824),
            word_row(OP_LOAD_A, 16'sh7fff),
            word_row(OP_LOAD_A, 16'sd5),             // A already full: dropped
            word_row(OP_LOAD_B, 16'sh8000, 1'b1, -36'sd1073709056),
            reg_row(REG_ROWS_A, 4'd15),              // clamps to MAX_DIM
            reg_row(REG_INNER_DIM, 4'd1),
            reg_row(REG_COLS_B, 4'd1),
            word_row(OP_LOAD_A, 16'sh7fff),
            word_row(OP_LOAD_A, 16'sh8000),
            word_row(OP_LOAD_A, 16'sh0100),
            word_row(OP_LOAD_A, -16'sh0100),
            word_row(OP_LOAD_A, 16'sh0001),
            word_row(OP_LOAD_A, -16'sh0001),
            word_row(OP_LOAD_A, 16'sh0000),
            word_row(OP_LOAD_A, 16'sh5a5a),
            word_row(OP_LOAD_B, 16'sha5a5),
            reg_row(REG_ROWS_A, 4'd2),
            reg_row(REG_INNER_DIM, 4'd2),
            reg_row(REG_COLS_B, 4'd2),
            word_row(OP_LOAD_A, 16'sh0100),
            word_row(OP_LOAD_B, 16'sh7fff),
            word_row(OP_LOAD_A, -16'sh0200),
            word_row(OP_LOAD_B, 16'sh8000),
            word_row(OP_LOAD_B, 16'sd1234),
            word_row(OP_LOAD_A, 16'sd3),
            word_row(OP_LOAD_B, -16'sd1),
            reg_row(REG_ROWS_A, 4'd1),               // shrink mid-load: A now complete
            word_row(OP_LOAD_A, 16'sd77)             // dropped, product comes out
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[n]) begin
            s = plan[n];
            if (s.is_reg) begin
                settle();
                write_reg(s.idx, s.data);
            end else begin
                offer_word(s.op, s.val);
                produced = predict_word(s.op, s.val, took);
                if (s.typed) begin
                    fixed = product_q.pop_back();
                    fixed.value = s.typed_value;
                    product_q.push_back(fixed);
                end
            end
        end

        // random products; config only changes with both counts at zero
        counted = 0;
        ph = 0;
        while (counted < RANDOM_WORDS) begin
            if (ph == 0 || ph == 5 || ph == 9 || (ph > 3 && $urandom_range(0, 2) == 0)) begin
                settle();
                write_reg(REG_ROWS_A, pick_dim(ph == 5, ph == 9));
                write_reg(REG_INNER_DIM, pick_dim(ph == 9, ph == 5));
                write_reg(REG_COLS_B, pick_dim(ph == 5, ph == 9));
            end
            if (ph == 0) hold_req <= 1'b1;
            calm = ($urandom_range(0, 3) == 0);
            size_a = eff_dim(dim_reg[REG_ROWS_A]) * eff_dim(dim_reg[REG_INNER_DIM]);
            size_b = eff_dim(dim_reg[REG_INNER_DIM]) * eff_dim(dim_reg[REG_COLS_B]);
            do begin
                if (loaded_a >= size_a) op = OP_LOAD_B;
                else if (loaded_b >= size_b) op = OP_LOAD_A;
                else op = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 9) == 0) op = 1'($urandom_range(0, 1));
                val = pick_value();
                offer_word(op, val);
                produced = predict_word(op, val, took);
                if (took) counted++;
            end while (produced == 0);
            ph++;
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && product_q.size() == 0) begin
            $display("PASS matrix_multiply_core");
        end else begin
            $display("FAIL matrix_multiply_core");
        end
        $finish;
    end

    // receiver: random stall modes, plus one long hold-off to back up the core
    initial begin : rx_stall
        int left;
        int mode;
        int hold_left;
        bit hold_done;
        left      = 0;
        mode      = 0;
        hold_left = 0;
        hold_done = 1'b0;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_if.ready <= 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 2);
                    left = $urandom_range(8, 64);
                end
                left--;
                case (mode)
                    0: out_if.ready <= 1'b1;
                    1: out_if.ready <= 1'($urandom_range(0, 1));
                    default: out_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : check_word
        t_product got;
        t_product want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.value = out_if.product_value;
            got.row   = out_if.out_row;
            got.col   = out_if.out_col;
            got.last  = out_if.last_element;
            if (product_q.size() == 0) begin
                $display("%0t: unexpected word value %0d row %0d col %0d last %0b",
                         $time, got.value, got.row, got.col, got.last);
                fail_count++;
            end else begin
                want = product_q.pop_front();
                if (got.value !== want.value || got.row !== want.row ||
                    got.col !== want.col || got.last !== want.last) begin
                    $display("%0t: expected value %0d row %0d col %0d last %0b",
                             $time, want.value, want.row, want.col, want.last);
                    $display("%0t:      got value %0d row %0d col %0d last %0b",
                             $time, got.value, got.row, got.col, got.last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, quiet);
            $display("FAIL matrix_multiply_core");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

endmodule
